>>> hdl/lcrs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the LED cube refresh serializer.
// No dependencies; every other file in the block but lcrs_ram imports this package.
package lcrs_pkg;

   localparam int CMD_W       = 2;
   localparam int IDX_W       = 3;
   localparam int ROW_W       = 8;
   localparam int WORD_W      = 16;
   localparam int STORE_DEPTH = 64;
   localparam int ADDR_W      = 6;
   localparam int GRP_W       = 2;
   localparam int SETUP_GROUPS = 4;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 8;
   localparam int NIBBLE_W    = 4;

   // Command codes of an input item
   localparam logic [CMD_W-1:0] CMD_SET     = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REFRESH = 2'd2;
   localparam logic [CMD_W-1:0] CMD_SETUP   = 2'd3;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DECODE_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTENSITY   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCAN_LIMIT  = 2'd2;

   localparam logic [CSR_DATA_W-1:0] DECODE_MODE_RST = 8'h00;
   localparam logic [NIBBLE_W-1:0]   INTENSITY_RST   = 4'h9;
   localparam logic [NIBBLE_W-1:0]   SCAN_LIMIT_RST  = 4'hF;

   // Driver register addresses and data
   localparam logic [ROW_W-1:0] ADDR_DECODE     = 8'h09;
   localparam logic [ROW_W-1:0] ADDR_INTENSITY  = 8'h0A;
   localparam logic [ROW_W-1:0] ADDR_SCAN_LIMIT = 8'h0B;
   localparam logic [ROW_W-1:0] ADDR_SHUTDOWN   = 8'h0C;
   localparam logic [ROW_W-1:0] NORMAL_OP       = 8'h01;

   // Controller to datapath
   typedef struct packed {
      logic             accept;
      logic             issue;
      logic [CMD_W-1:0] op;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] plane;
      logic [GRP_W-1:0] group;
      logic             latch;
      logic             last;
   } lcrs_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic can_issue;
      logic pipe_empty;
   } lcrs_stat_type;

endpackage

>>> hdl/lcrs_chan.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and response sides.
// Depends on lcrs_pkg for field widths.
interface lcrs_req_chan;
   import lcrs_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CMD_W-1:0]     cmd;
   logic [IDX_W-1:0]     plane;
   logic [IDX_W-1:0]     row;
   logic [IDX_W-1:0]     column;
   logic                 voxel_on;

   modport source (output valid, output cmd, output plane, output row, output column,
                   output voxel_on, input ready);
   modport sink (input valid, input cmd, input plane, input row, input column,
                 input voxel_on, output ready);
endinterface

interface lcrs_rsp_chan;
   import lcrs_pkg::*;
   logic              valid;
   logic              ready;
   logic              result_kind;
   logic [WORD_W-1:0] driver_word;
   logic              latch_now;
   logic              read_value;
   logic              last;

   modport source (output valid, output result_kind, output driver_word, output latch_now,
                   output read_value, output last, input ready);
   modport sink (input valid, input result_kind, input driver_word, input latch_now,
                 input read_value, input last, output ready);
endinterface

>>> hdl/lcrs_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lcrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hdl/lcrs_ctrl.sv
`timescale 1ns / 1ps
// Sequencing controller: takes commands and walks word counters.
// Depends on lcrs_pkg.
module lcrs_ctrl import lcrs_pkg::*; #(
   parameter int CUBE_SIZE = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [CMD_W-1:0] req_cmd,
   output logic             req_ready,
   input  lcrs_stat_type    stat,
   output lcrs_cmd_type     ctl
);
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(CUBE_SIZE - 1);
   localparam logic [IDX_W-1:0] LAST_GRP  = IDX_W'(SETUP_GROUPS - 1);

   logic             state_ff, state_in;
   logic [CMD_W-1:0] op_ff, op_in;
   logic [IDX_W-1:0] outer_ff, outer_in;
   logic [IDX_W-1:0] inner_ff, inner_in;
   logic             accept, single, inner_end, outer_end, final_word, step;

   assign req_ready  = (state_ff == ST_IDLE) && stat.pipe_empty;
   assign accept     = req_valid && req_ready;
   assign single     = (op_ff == CMD_SET) || (op_ff == CMD_READ);
   assign inner_end  = (inner_ff == LAST_IDX);
   assign outer_end  = (op_ff == CMD_SETUP) ? (outer_ff == LAST_GRP) : (outer_ff == LAST_IDX);
   assign final_word = single || (inner_end && outer_end);
   assign step       = (state_ff == ST_RUN) && stat.can_issue;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      outer_in = outer_ff;
      inner_in = inner_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RUN;
               op_in    = req_cmd;
               outer_in = '0;
               inner_in = '0;
            end
         end
         ST_RUN: begin
            if (step) begin
               if (final_word) begin
                  state_in = ST_IDLE;
               end else if (inner_end) begin
                  inner_in = '0;
                  outer_in = outer_ff + 1'b1;
               end else begin
                  inner_in = inner_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= CMD_SET;
         outer_ff <= '0;
         inner_ff <= '0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         outer_ff <= outer_in;
         inner_ff <= inner_in;
      end
   end

   // Refresh walks planes from the top of the chain down
   assign ctl.accept = accept;
   assign ctl.issue  = step;
   assign ctl.op     = op_ff;
   assign ctl.row    = outer_ff;
   assign ctl.plane  = LAST_IDX - inner_ff;
   assign ctl.group  = outer_ff[GRP_W-1:0];
   assign ctl.latch  = inner_end;
   assign ctl.last   = final_word;

   a_inner_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (inner_ff <= LAST_IDX))
      else $error("word counter ran past the chain length");

   a_outer_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && op_ff == CMD_SETUP) |-> (outer_ff <= LAST_GRP))
      else $error("setup group counter ran past the last register");

   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && op_ff != CMD_SETUP) |-> (outer_ff <= LAST_IDX))
      else $error("row counter ran past the cube size");
endmodule

>>> hdl/lcrs_dp.sv
`timescale 1ns / 1ps
// Datapath: voxel store, config registers, read stage and output register.
// Depends on lcrs_pkg and lcrs_ram.
module lcrs_dp import lcrs_pkg::*; #(
   parameter int CUBE_SIZE = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [IDX_W-1:0]      req_plane,
   input  logic [IDX_W-1:0]      req_row,
   input  logic [IDX_W-1:0]      req_column,
   input  logic                  req_voxel_on,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   input  lcrs_cmd_type          ctl,
   output lcrs_stat_type         stat,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic                  rsp_result_kind,
   output logic [WORD_W-1:0]     rsp_driver_word,
   output logic                  rsp_latch_now,
   output logic                  rsp_read_value,
   output logic                  rsp_last
);
   localparam logic [IDX_W:0] SIZE = (IDX_W + 1)'(CUBE_SIZE);

   // request fields, held for the whole item
   logic [IDX_W-1:0] plane_ff, row_ff, column_ff;
   logic             on_ff, inside_ff;
   logic             inside_in;

   logic [CSR_DATA_W-1:0] decode_mode_ff;
   logic [NIBBLE_W-1:0]   intensity_ff, scan_limit_ff;

   logic [STORE_DEPTH-1:0] entry_ok_ff;

   // read stage
   logic              s1_valid_ff, s1_valid_in;
   logic [CMD_W-1:0]  s1_op_ff;
   logic [IDX_W-1:0]  s1_row_ff;
   logic [GRP_W-1:0]  s1_group_ff;
   logic              s1_latch_ff, s1_last_ff, s1_hit_ff;
   logic [ADDR_W-1:0] s1_addr_ff;

   // output register
   logic              out_valid_ff, out_valid_in;
   logic              out_kind_ff, out_kind_in;
   logic [WORD_W-1:0] out_word_ff, out_word_in;
   logic              out_latch_ff, out_latch_in;
   logic              out_rv_ff, out_rv_in;
   logic              out_last_ff, out_last_in;

   logic              single, out_free, s1_adv, out_load, ram_wr_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [ROW_W-1:0]  ram_rd_data, row_byte, bit_mask, wr_data;
   logic [ROW_W-1:0]  setup_addr, setup_data;

   assign inside_in = ({1'b0, req_plane} < SIZE) && ({1'b0, req_row} < SIZE)
                      && ({1'b0, req_column} < SIZE);

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         plane_ff  <= req_plane;
         row_ff    <= req_row;
         column_ff <= req_column;
         on_ff     <= req_voxel_on;
         inside_ff <= inside_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decode_mode_ff <= DECODE_MODE_RST;
         intensity_ff   <= INTENSITY_RST;
         scan_limit_ff  <= SCAN_LIMIT_RST;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_DECODE_MODE) begin
            decode_mode_ff <= csr_wr_data;
         end
         if (csr_index == CSR_INTENSITY) begin
            intensity_ff <= csr_wr_data[NIBBLE_W-1:0];
         end
         if (csr_index == CSR_SCAN_LIMIT) begin
            scan_limit_ff <= csr_wr_data[NIBBLE_W-1:0];
         end
      end
   end

   assign single   = (ctl.op == CMD_SET) || (ctl.op == CMD_READ);
   assign rd_addr  = single ? {plane_ff, row_ff} : {ctl.plane, ctl.row};
   assign out_free = !out_valid_ff || rsp_ready;
   // a set retires from the read stage without a result
   assign s1_adv   = s1_valid_ff && ((s1_op_ff == CMD_SET) || out_free);
   assign out_load = s1_adv && (s1_op_ff != CMD_SET);

   // entries never written read as dark
   assign row_byte  = s1_hit_ff ? ram_rd_data : '0;
   assign bit_mask  = ROW_W'(1) << column_ff;
   assign wr_data   = on_ff ? (row_byte | bit_mask) : (row_byte & ~bit_mask);
   assign ram_wr_en = s1_adv && (s1_op_ff == CMD_SET) && inside_ff;

   lcrs_ram #(
      .WIDTH (ROW_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_data),
      .rd_en   (ctl.issue),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ok_ff <= '0;
      end else if (ram_wr_en) begin
         entry_ok_ff[s1_addr_ff] <= 1'b1;
      end
   end

   assign s1_valid_in = ctl.issue ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.issue) begin
         s1_op_ff    <= ctl.op;
         s1_row_ff   <= ctl.row;
         s1_group_ff <= ctl.group;
         s1_latch_ff <= ctl.latch;
         s1_last_ff  <= ctl.last;
         s1_hit_ff   <= entry_ok_ff[rd_addr];
         s1_addr_ff  <= rd_addr;
      end
   end

   assign setup_addr = ADDR_DECODE + {{(ROW_W - GRP_W){1'b0}}, s1_group_ff};

   always_comb begin
      case (setup_addr)
         ADDR_DECODE:     setup_data = decode_mode_ff;
         ADDR_INTENSITY:  setup_data = {{(ROW_W - NIBBLE_W){1'b0}}, intensity_ff};
         ADDR_SCAN_LIMIT: setup_data = {{(ROW_W - NIBBLE_W){1'b0}}, scan_limit_ff};
         default:         setup_data = NORMAL_OP;
      endcase
   end

   always_comb begin
      out_kind_in  = 1'b0;
      out_word_in  = '0;
      out_latch_in = 1'b0;
      out_rv_in    = 1'b0;
      out_last_in  = s1_last_ff;
      case (s1_op_ff)
         CMD_READ: begin
            out_kind_in = 1'b1;
            out_rv_in   = inside_ff & row_byte[column_ff];
            out_last_in = 1'b1;
         end
         CMD_REFRESH: begin
            out_word_in  = {({{(ROW_W - IDX_W){1'b0}}, s1_row_ff} + 8'd1), row_byte};
            out_latch_in = s1_latch_ff;
         end
         CMD_SETUP: begin
            out_word_in  = {setup_addr, setup_data};
            out_latch_in = s1_latch_ff;
         end
         default: begin
            out_last_in = 1'b0;
         end
      endcase
   end

   assign out_valid_in = out_load ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_kind_ff  <= out_kind_in;
         out_word_ff  <= out_word_in;
         out_latch_ff <= out_latch_in;
         out_rv_ff    <= out_rv_in;
         out_last_ff  <= out_last_in;
      end
   end

   assign stat.can_issue  = !s1_valid_ff || s1_adv;
   assign stat.pipe_empty = !s1_valid_ff;

   assign rsp_valid       = out_valid_ff;
   assign rsp_result_kind = out_kind_ff;
   assign rsp_driver_word = out_word_ff;
   assign rsp_latch_now   = out_latch_ff;
   assign rsp_read_value  = out_rv_ff;
   assign rsp_last        = out_last_ff;

   a_no_rw_collide: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> !ctl.issue)
      else $error("store read issued while a set writes back");

   a_read_answer_shape: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_kind_ff) |-> (out_word_ff == '0 && !out_latch_ff && out_last_ff))
      else $error("read answer carries driver fields");

   a_word_has_addr: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_kind_ff) |-> (out_word_ff[WORD_W-1:ROW_W] != '0 && !out_rv_ff))
      else $error("driver word without register address");
endmodule

>>> hdl/led_cube_refresh_serializer.sv
`timescale 1ns / 1ps
// LED cube refresh serializer, top level.
// Depends on lcrs_pkg, lcrs_chan, lcrs_ram, lcrs_ctrl and lcrs_dp.
//
// Usage:
//   req_ch (valid/ready) takes one command item: set voxel, read voxel,
//   refresh all, or setup. rsp_ch (valid/ready) returns result items:
//   a read gives one answer, a refresh gives CUBE_SIZE*CUBE_SIZE driver
//   words (64 at the default size), a setup gives 4*CUBE_SIZE words; a set
//   gives nothing. The last result of an item carries last = 1.
//   csr_* writes decode_mode, intensity and scan_limit; write them only
//   while the block is idle.
// Timing:
//   The first result passes the controller state, the store read into the
//   read stage and the output register; words then stream one per cycle
//   while rsp_ch.ready allows, paced by the single store read port feeding
//   one read stage. The next item is taken once the read stage has
//   drained, even while the final result still sits in the output register.
// Reset:
//   Synchronous, active high. The cube reads dark right after reset: each
//   store entry has a written flag, cleared by reset, so no clearing pass.
// Stall:
//   When rsp_ch.ready is low the output register and read stage hold and
//   the word counters stop; nothing is lost or repeated.
module led_cube_refresh_serializer import lcrs_pkg::*; #(
   parameter int CUBE_SIZE = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   lcrs_req_chan.sink            req_ch,
   lcrs_rsp_chan.source          rsp_ch,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);
   lcrs_cmd_type  ctl;
   lcrs_stat_type stat;
   logic          req_ready;

   // Sequencer: accepts items and steps through the words of each
   lcrs_ctrl #(
      .CUBE_SIZE (CUBE_SIZE)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_cmd   (req_ch.cmd),
      .req_ready (req_ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   // Store, configuration and result formatting
   lcrs_dp #(
      .CUBE_SIZE (CUBE_SIZE)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_plane       (req_ch.plane),
      .req_row         (req_ch.row),
      .req_column      (req_ch.column),
      .req_voxel_on    (req_ch.voxel_on),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .ctl             (ctl),
      .stat            (stat),
      .rsp_ready       (rsp_ch.ready),
      .rsp_valid       (rsp_ch.valid),
      .rsp_result_kind (rsp_ch.result_kind),
      .rsp_driver_word (rsp_ch.driver_word),
      .rsp_latch_now   (rsp_ch.latch_now),
      .rsp_read_value  (rsp_ch.read_value),
      .rsp_last        (rsp_ch.last)
   );

   assign req_ch.ready = req_ready;
endmodule

>>> tb/sv/tb_led_cube_refresh_serializer.sv
`timescale 1ns / 1ps
// Self-checking testbench for led_cube_refresh_serializer: directed and random command items,
// with a scoreboard class that predicts every read answer, refresh word and setup word.
// Depends on lcrs_pkg and the lcrs_req_chan / lcrs_rsp_chan interfaces.
module tb_led_cube_refresh_serializer;
   import lcrs_pkg::*;

   localparam int CUBE            = 8;
   localparam int IDLE_PCT        = 34;
   localparam int SETTLE_CYCLES   = 12;   // a set gives no result, so let it retire
   localparam int HOLD_OFF_CYCLES = 400;  // long receiver stall that backs up the input
   localparam int RANDOM_PHASES   = 3;
   localparam int PHASE_ITEMS     = 84;
   localparam int CALM_ITEMS      = 40;
   // Index 3 maps to no register; a write there must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [IDX_W-1:0] plane;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] column;
      logic             voxel_on;
   } voxel_cmd_type;

   typedef struct packed {
      logic              result_kind;
      logic [WORD_W-1:0] driver_word;
      logic              latch_now;
      logic              read_value;
      logic              last;
   } cube_result_type;

   // Shadow of the voxel store and the setup registers, plus the queue of
   // driver words and read answers still owed by the block.
   class cube_word_scoreboard;
      logic [ROW_W-1:0]      lit_rows [STORE_DEPTH];
      logic [CSR_DATA_W-1:0] decode_byte;
      logic [NIBBLE_W-1:0]   intensity_nib;
      logic [NIBBLE_W-1:0]   scan_nib;
      cube_result_type       pending_words [$];
      int                    errors;

      function new();
         foreach (lit_rows[i]) lit_rows[i] = '0;
         decode_byte   = DECODE_MODE_RST;
         intensity_nib = INTENSITY_RST;
         scan_nib      = SCAN_LIMIT_RST;
         errors        = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_DECODE_MODE: decode_byte   = data;
            CSR_INTENSITY:   intensity_nib = data[NIBBLE_W-1:0];
            CSR_SCAN_LIMIT:  scan_nib      = data[NIBBLE_W-1:0];
            default: ;
         endcase
      endfunction

      function void push_word(logic [ROW_W-1:0] addr, logic [ROW_W-1:0] data,
                              logic latch, logic fin);
         cube_result_type w;
         w.result_kind = 1'b0;
         w.driver_word = {addr, data};
         w.latch_now   = latch;
         w.read_value  = 1'b0;
         w.last        = fin;
         pending_words.push_back(w);
      endfunction

      // One word per driver in the chain; the last copy latches.
      function void push_group(logic [ROW_W-1:0] addr, logic [ROW_W-1:0] data, logic closing);
         for (int i = 0; i < CUBE; i++)
            push_word(addr, data, i == CUBE - 1, closing && i == CUBE - 1);
      endfunction

      function void note_item(voxel_cmd_type it);
         cube_result_type ans;
         logic [ADDR_W-1:0] slot;
         slot = {it.plane, it.row};
         case (it.cmd)
            CMD_SET: lit_rows[slot][it.column] = it.voxel_on;
            CMD_READ: begin
               ans             = '0;
               ans.result_kind = 1'b1;
               ans.read_value  = lit_rows[slot][it.column];
               ans.last        = 1'b1;
               pending_words.push_back(ans);
            end
            CMD_REFRESH: begin
               for (int r = 0; r < CUBE; r++)
                  for (int p = CUBE - 1; p >= 0; p--)
                     push_word(ROW_W'(r + 1), lit_rows[p * 8 + r], p == 0,
                               p == 0 && r == CUBE - 1);
            end
            CMD_SETUP: begin
               push_group(ADDR_DECODE, decode_byte, 1'b0);
               push_group(ADDR_INTENSITY, {4'b0, intensity_nib}, 1'b0);
               push_group(ADDR_SCAN_LIMIT, {4'b0, scan_nib}, 1'b0);
               push_group(ADDR_SHUTDOWN, NORMAL_OP, 1'b1);
            end
            default: ;
         endcase
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            errors++;
            $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
         end
      endfunction

      function void check_word(cube_result_type got);
         cube_result_type want;
         if (pending_words.size() == 0) begin
            errors++;
            $display("%0t ns: result expected none actual %h", $time, got);
            return;
         end
         want = pending_words.pop_front();
         compare_field("result_kind", want.result_kind, got.result_kind);
         compare_field("driver_word", want.driver_word, got.driver_word);
         compare_field("latch_now", want.latch_now, got.latch_now);
         compare_field("read_value", want.read_value, got.read_value);
         compare_field("last", want.last, got.last);
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   // Pacing knobs owned by the stimulus process, read by the receiver.
   bit calm_source;
   bit calm_sink;
   bit squeeze_armed;

   cube_word_scoreboard sb = new();

   lcrs_req_chan req_ch ();
   lcrs_rsp_chan rsp_ch ();

   led_cube_refresh_serializer #(.CUBE_SIZE(CUBE)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic voxel_cmd_type cmd_item(logic [CMD_W-1:0] cmd, int plane, int row,
                                              int column, bit on);
      voxel_cmd_type it;
      it.cmd      = cmd;
      it.plane    = IDX_W'(plane);
      it.row      = IDX_W'(row);
      it.column   = IDX_W'(column);
      it.voxel_on = on;
      return it;
   endfunction

   // Mostly sets and reads so the cube fills up and reads see lit voxels;
   // refreshes and setups are the long bursts.
   function automatic voxel_cmd_type random_item();
      voxel_cmd_type it;
      int pick;
      it.plane    = IDX_W'($urandom_range(CUBE - 1));
      it.row      = IDX_W'($urandom_range(CUBE - 1));
      it.column   = IDX_W'($urandom_range(CUBE - 1));
      it.voxel_on = ($urandom_range(99) < 70);
      pick = $urandom_range(99);
      if (pick < 45)      it.cmd = CMD_SET;
      else if (pick < 75) it.cmd = CMD_READ;
      else if (pick < 90) it.cmd = CMD_REFRESH;
      else                it.cmd = CMD_SETUP;
      return it;
   endfunction

   // Offer one item, idling at random first; return at the accepting edge.
   // Valid stays high into the next item unless that item idles first.
   task automatic send_item(voxel_cmd_type it);
      while (!calm_source && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.cmd      <= it.cmd;
      req_ch.plane    <= it.plane;
      req_ch.row      <= it.row;
      req_ch.column   <= it.column;
      req_ch.voxel_on <= it.voxel_on;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_item(it);
   endtask

   // Drop valid, wait for every owed result, then let a trailing set retire.
   task automatic drain_block();
      req_ch.valid <= 1'b0;
      while (sb.pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   // Only called while the block is idle.
   task automatic apply_settings(logic [CSR_DATA_W-1:0] dm, logic [CSR_DATA_W-1:0] inten,
                                 logic [CSR_DATA_W-1:0] scan, bit stray_write);
      write_csr(CSR_DECODE_MODE, dm);
      write_csr(CSR_INTENSITY, inten);
      write_csr(CSR_SCAN_LIMIT, scan);
      if (stray_write) write_csr(CSR_UNMAPPED, 8'hA5);
      csr_wr_en <= 1'b0;
   endtask

   // Receiver: check each accepted result, then pick ready for the next
   // cycle. Once armed, hold off for a long counted stretch so the block
   // backs up into its input while the sender keeps offering items.
   initial begin
      int hold_left;
      bit squeezed;
      hold_left = 0;
      squeezed  = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready)
            sb.check_word({rsp_ch.result_kind, rsp_ch.driver_word, rsp_ch.latch_now,
                           rsp_ch.read_value, rsp_ch.last});
         if (squeeze_armed && !squeezed) begin
            hold_left = HOLD_OFF_CYCLES;
            squeezed  = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else if (calm_sink) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Stimulus
   initial begin
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.cmd      <= CMD_SET;
      req_ch.plane    <= '0;
      req_ch.row      <= '0;
      req_ch.column   <= '0;
      req_ch.voxel_on <= 1'b0;
      csr_wr_en       <= 1'b0;
      csr_index       <= CSR_DECODE_MODE;
      csr_wr_data     <= '0;
      calm_source     <= 1'b0;
      calm_sink       <= 1'b0;
      squeeze_armed   <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Dark cube under reset settings: a read, the setup words, a refresh.
      send_item(cmd_item(CMD_READ, 0, 0, 0, 1'b0));
      send_item(cmd_item(CMD_SETUP, 0, 0, 0, 1'b0));
      send_item(cmd_item(CMD_REFRESH, 0, 0, 0, 1'b0));
      // Light the corners, then clear one voxel again in a shared row byte.
      send_item(cmd_item(CMD_SET, 0, 0, 0, 1'b1));
      send_item(cmd_item(CMD_SET, 7, 7, 7, 1'b1));
      send_item(cmd_item(CMD_SET, 7, 0, 7, 1'b1));
      send_item(cmd_item(CMD_SET, 0, 7, 0, 1'b1));
      send_item(cmd_item(CMD_SET, 3, 5, 2, 1'b1));
      send_item(cmd_item(CMD_SET, 3, 5, 6, 1'b1));
      send_item(cmd_item(CMD_SET, 3, 5, 2, 1'b0));
      send_item(cmd_item(CMD_READ, 0, 0, 0, 1'b0));
      send_item(cmd_item(CMD_READ, 7, 7, 7, 1'b0));
      send_item(cmd_item(CMD_READ, 3, 5, 2, 1'b0));
      send_item(cmd_item(CMD_READ, 3, 5, 6, 1'b0));
      send_item(cmd_item(CMD_READ, 5, 3, 1, 1'b0));
      send_item(cmd_item(CMD_REFRESH, 0, 0, 0, 1'b0));
      drain_block();

      // Top decode and intensity, zero scan limit; the intensity write carries extra high
      // bits that must be dropped, and a write to the unmapped index must change nothing.
      apply_settings(8'hFF, 8'hFF, 8'h00, 1'b1);
      send_item(cmd_item(CMD_SETUP, 7, 7, 7, 1'b1));
      send_item(cmd_item(CMD_READ, 7, 0, 7, 1'b1));
      drain_block();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         if (ph == RANDOM_PHASES - 1)
            apply_settings(8'h00, 8'h00, 8'h0F, 1'b0);
         else
            apply_settings(CSR_DATA_W'($urandom_range(255)), CSR_DATA_W'($urandom_range(255)),
                           CSR_DATA_W'($urandom_range(255)), 1'b0);
         // Open the first phase at full rate on both sides.
         calm_source <= (ph == 0);
         calm_sink   <= (ph == 0);
         // Stall the receiver early in the second phase.
         if (ph == 1) squeeze_armed <= 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 0 && n == CALM_ITEMS) begin
               calm_source <= 1'b0;
               calm_sink   <= 1'b0;
            end
            send_item(random_item());
         end
         drain_block();
      end

      if (sb.errors == 0 && sb.pending_words.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

>>> filelist.f
hdl/lcrs_pkg.sv
hdl/lcrs_chan.sv
hdl/lcrs_ram.sv
hdl/lcrs_ctrl.sv
hdl/lcrs_dp.sv
hdl/led_cube_refresh_serializer.sv
tb/sv/tb_led_cube_refresh_serializer.sv
